>>> hdl/shs_pkg.sv
`timescale 1ns / 1ps
// shs_pkg: field widths, operation and status codes, cell control type
// for the shadowing handler stack; no dependencies
package shs_pkg;

  localparam int KEY_W           = 64;
  localparam int HND_W           = 64;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 6;
  localparam int DEF_STACK_DEPTH = 32;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT = 2'd3;

  typedef struct packed {
    logic load_cmp;
    logic ripple;
    logic shift;
  } cell_ctl_t;

endpackage

>>> hdl/shs_in_if.sv
`timescale 1ns / 1ps
// shs_in_if: input item channel (valid, ready, mode, key, handler)
// depends on shs_pkg
interface shs_in_if;
  import shs_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  logic [HND_W-1:0]  handler;

  modport source (output valid, mode, key, handler, input ready);
  modport sink   (input valid, mode, key, handler, output ready);
endinterface

>>> hdl/shs_out_if.sv
`timescale 1ns / 1ps
// shs_out_if: result item channel (valid, ready, status, found, found_handler, depth)
// depends on shs_pkg
interface shs_out_if;
  import shs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [HND_W-1:0]    found_handler;
  logic [DEPTH_W-1:0]  depth;

  modport source (output valid, status, found, found_handler, depth, input ready);
  modport sink   (input valid, status, found, found_handler, depth, output ready);
endinterface

>>> hdl/shadowing_handler_stack_unit.sv
`timescale 1ns / 1ps
// shadowing_handler_stack_unit: top level, control sequencer and a row of shs_cell slots
// depends on shs_pkg, shs_in_if, shs_out_if, shs_cell
//
// A bounded LIFO of (key, handler) pairs where a newer entry shadows older ones with the
// same key. Each slot is a cell; on pop and lookup every cell compares its key at once, then
// the "match above" flag and the topmost matching handler travel down the row one cell per
// cycle. A pop moves every slot above the removed one down by one, all at the same time.
// One item is worked on at a time; the next item is taken while the previous result still
// waits in the output register.
module shadowing_handler_stack_unit #(
  parameter int STACK_DEPTH = shs_pkg::DEF_STACK_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  shs_in_if.sink    in_ch,
  shs_out_if.source out_ch
);
  import shs_pkg::*;

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W  = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int LAST   = (STACK_DEPTH > 1) ? STACK_DEPTH - 2 : 0;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_RIPPLE = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [KEY_W-1:0]    key_r;
  logic [HND_W-1:0]    handler_r;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [HND_W-1:0]    res_hand_r, res_hand_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [HND_W-1:0]    out_hand_r;
  logic [DEPTH_W-1:0]  out_depth_r;
  logic                out_load;
  logic                push_go;
  cell_ctl_t           ctl;

  logic [KEY_W-1:0] c_key     [STACK_DEPTH+1];
  logic [HND_W-1:0] c_handler [STACK_DEPTH+1];
  logic             c_match   [STACK_DEPTH+1];
  logic             c_above   [STACK_DEPTH+1];
  logic [HND_W-1:0] c_hand    [STACK_DEPTH+1];
  logic             found_any;
  logic [HND_W-1:0] found_hand;

  logic in_fire;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // nothing above the top cell
  assign c_key[STACK_DEPTH]     = '0;
  assign c_handler[STACK_DEPTH] = '0;
  assign c_match[STACK_DEPTH]   = 1'b0;
  assign c_above[STACK_DEPTH]   = 1'b0;
  assign c_hand[STACK_DEPTH]    = '0;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      shs_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .push_en    (push_go && (fill_r == FILL_W'(gi))),
        .valid      (FILL_W'(gi) < fill_r),
        .found_any  (found_any),
        .in_key     (key_r),
        .in_handler (handler_r),
        .up_key     (c_key[gi+1]),
        .up_handler (c_handler[gi+1]),
        .up_match   (c_match[gi+1]),
        .up_above   (c_above[gi+1]),
        .up_hand    (c_hand[gi+1]),
        .key        (c_key[gi]),
        .handler    (c_handler[gi]),
        .match      (c_match[gi]),
        .above      (c_above[gi]),
        .hand       (c_hand[gi])
      );
    end
  endgenerate

  assign found_any  = c_match[0] | c_above[0];
  assign found_hand = c_above[0] ? c_hand[0] : (c_match[0] ? c_handler[0] : '0);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_hand_nxt   = res_hand_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_load       = 1'b0;
    push_go        = 1'b0;
    ctl            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        res_status_nxt = STATUS_OK;
        res_found_nxt  = 1'b0;
        res_hand_nxt   = '0;
        cnt_nxt        = '0;
        case (mode_r)
          MODE_PUSH: begin
            if (fill_r >= FILL_W'(STACK_DEPTH)) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              push_go  = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end
            state_nxt = ST_FINISH;
          end
          MODE_CLEAR: begin
            fill_nxt  = '0;
            state_nxt = ST_FINISH;
          end
          MODE_POP: begin
            if (fill_r == '0) begin
              res_status_nxt = STATUS_EMPTY;
              state_nxt      = ST_FINISH;
            end else begin
              ctl.load_cmp = 1'b1;
              state_nxt    = (STACK_DEPTH > 1) ? ST_RIPPLE : ST_EVAL;
            end
          end
          default: begin
            ctl.load_cmp = 1'b1;
            state_nxt    = (STACK_DEPTH > 1) ? ST_RIPPLE : ST_EVAL;
          end
        endcase
      end
      ST_RIPPLE: begin
        ctl.ripple = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LAST)) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (found_any) begin
          if (mode_r == MODE_POP) begin
            ctl.shift = 1'b1;
            fill_nxt  = fill_r - FILL_W'(1);
          end else begin
            res_found_nxt = 1'b1;
            res_hand_nxt  = found_hand;
          end
        end else begin
          res_status_nxt = STATUS_NOT_PRESENT;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r    <= in_ch.mode;
      key_r     <= in_ch.key;
      handler_r <= in_ch.handler;
    end
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_hand_r   <= res_hand_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_hand_r   <= res_hand_r;
      out_depth_r  <= DEPTH_W'(fill_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.found_handler = out_hand_r;
  assign out_ch.depth         = out_depth_r;
endmodule

>>> hdl/shs_cell.sv
`timescale 1ns / 1ps
// shs_cell: one stack slot holding a key/handler pair, its match flag and the
// match-above flag and handler that ripple down from the neighbor; depends on shs_pkg
module shs_cell (
  input  logic                    clk,
  input  shs_pkg::cell_ctl_t      ctl,
  input  logic                    push_en,
  input  logic                    valid,
  input  logic                    found_any,
  input  logic [shs_pkg::KEY_W-1:0] in_key,
  input  logic [shs_pkg::HND_W-1:0] in_handler,
  input  logic [shs_pkg::KEY_W-1:0] up_key,
  input  logic [shs_pkg::HND_W-1:0] up_handler,
  input  logic                    up_match,
  input  logic                    up_above,
  input  logic [shs_pkg::HND_W-1:0] up_hand,
  output logic [shs_pkg::KEY_W-1:0] key,
  output logic [shs_pkg::HND_W-1:0] handler,
  output logic                    match,
  output logic                    above,
  output logic [shs_pkg::HND_W-1:0] hand
);
  import shs_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [HND_W-1:0] handler_r;
  logic             match_r;
  logic             above_r;
  logic [HND_W-1:0] hand_r;

  always_ff @(posedge clk) begin
    if (push_en) begin
      key_r     <= in_key;
      handler_r <= in_handler;
    end else if (ctl.shift && found_any && !above_r) begin
      key_r     <= up_key;
      handler_r <= up_handler;
    end
    if (ctl.load_cmp) begin
      match_r <= valid && (key_r == in_key);
      above_r <= 1'b0;
      hand_r  <= '0;
    end else if (ctl.ripple) begin
      above_r <= up_above | up_match;
      hand_r  <= up_above ? up_hand : (up_match ? up_handler : '0);
    end
  end

  assign key     = key_r;
  assign handler = handler_r;
  assign match   = match_r;
  assign above   = above_r;
  assign hand    = hand_r;
endmodule
